>>> rtl/nkc_pkg.sv
// ----------------------------------------------------------------------------
// nkc_pkg: neighbor key classifier shared definitions
// Field widths, key layout constants, the per-group decode table and the
// count update shared by the pipeline stages.
// ----------------------------------------------------------------------------
package nkc_pkg;

	localparam int KEY_W             = 30;
	localparam int FIRST_NEIGHBORS   = 4;
	localparam int SECONDS_PER_FIRST = 3;
	localparam int SLOT_RADIX        = 5;
	localparam int SLOT_ABSENT       = 4;
	localparam int SLOT_VOLUME       = 3;

	localparam int FIRST_W  = 3;
	localparam int SECOND_W = 4;
	localparam int CODE_W   = 14;
	localparam int DIGIT_W  = 4;

	localparam int DEC_RADIX     = 10;
	localparam int DEC_TENS      = 10;
	localparam int DEC_HUNDREDS  = 100;
	localparam int DEC_THOUSANDS = 1000;

	localparam int PRESENT_W   = $clog2(FIRST_NEIGHBORS);
	localparam int REST_W      = KEY_W - PRESENT_W;
	localparam int GROUP_RADIX = SLOT_RADIX ** SECONDS_PER_FIRST;
	localparam int GROUP_BITS  = $clog2(GROUP_RADIX);
	localparam int GROUP_SHIFT = GROUP_BITS - 1;
	localparam int SLOT_CNT_W  = $clog2(SECONDS_PER_FIRST + 1);
	localparam int TAIL_W      = REST_W - (FIRST_NEIGHBORS - 1) * GROUP_SHIFT;

	localparam int IN_TDATA_W = ((KEY_W + 7) / 8) * 8;

	typedef logic [GROUP_BITS-1:0] nkc_group_val_t;

	typedef struct packed {
		logic                  missing;
		logic [SLOT_CNT_W-1:0] volume;
		logic [SLOT_CNT_W-1:0] surface;
		logic [SLOT_CNT_W-1:0] exist;
	} nkc_group_t;

	typedef nkc_group_t [(1 << GROUP_BITS)-1:0] nkc_group_tab_t;

	typedef struct packed {
		logic [FIRST_W-1:0]  present;
		logic [FIRST_W-1:0]  surface_first;
		logic [FIRST_W-1:0]  volume_first;
		logic [SECOND_W-1:0] volume_second;
		logic [SECOND_W-1:0] surface_second;
		logic [SECOND_W-1:0] indirect_second;
	} nkc_counts_t;

	typedef struct packed {
		logic [CODE_W-1:0]   class_code;
		logic [SECOND_W-1:0] indirect_second;
		logic [SECOND_W-1:0] surface_second;
		logic [SECOND_W-1:0] volume_second;
		logic [FIRST_W-1:0]  volume_first;
		logic [FIRST_W-1:0]  surface_first;
		logic [FIRST_W-1:0]  first_present;
	} nkc_result_t;

	localparam int RESULT_W    = $bits(nkc_result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	function automatic nkc_group_tab_t build_group_table();
		nkc_group_tab_t tab;
		int unsigned    v;
		int unsigned    d;
		for (int g = 0; g < (1 << GROUP_BITS); g++) begin
			tab[g] = '0;
			v = g;
			for (int s = 0; s < SECONDS_PER_FIRST; s++) begin
				d = v % SLOT_RADIX;
				v = v / SLOT_RADIX;
				if (d == SLOT_ABSENT) begin
					tab[g].missing = 1'b1;
				end else begin
					tab[g].exist = tab[g].exist + 1'b1;
					if (d == SLOT_VOLUME) begin
						tab[g].volume = tab[g].volume + 1'b1;
					end else begin
						tab[g].surface = tab[g].surface + 1'b1;
					end
				end
			end
		end
		return tab;
	endfunction

	localparam nkc_group_tab_t GROUP_TABLE = build_group_table();

	// fold one first neighbor's slot group into the running counts
	function automatic nkc_counts_t add_group(nkc_counts_t c, nkc_group_t info,
			int unsigned f);
		nkc_counts_t r;
		r = c;
		if (c.present > FIRST_W'(f)) begin
			r.volume_second  = c.volume_second + SECOND_W'(info.volume);
			r.surface_second = c.surface_second + SECOND_W'(info.surface);
			if (info.missing) begin
				r.surface_first = c.surface_first + 1'b1;
			end else begin
				r.volume_first = c.volume_first + 1'b1;
			end
		end else begin
			r.indirect_second = c.indirect_second + SECOND_W'(info.exist);
		end
		return r;
	endfunction

	function automatic logic [DIGIT_W-1:0] mod_ten(logic [SECOND_W-1:0] v);
		logic [SECOND_W-1:0] r;
		r = (v >= SECOND_W'(DEC_RADIX)) ? v - SECOND_W'(DEC_RADIX) : v;
		return DIGIT_W'(r);
	endfunction

endpackage

>>> rtl/neighbor_key_classifier_core.sv
// ----------------------------------------------------------------------------
// neighbor_key_classifier_core: lattice neighborhood key classifier
// Input register, group stages and result stage lie between the input
// transaction and m_axis_tvalid. One transaction per cycle unless the output
// stalls; each group stage holds one reciprocal multiplier that splits one
// base-125 slot group off the key. Reset clears the stage valid flags only.
// ----------------------------------------------------------------------------
module neighbor_key_classifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// neighbor_key
	input  logic [nkc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// first_present, surface_first, volume_first, volume_second,
	// surface_second, indirect_second, class_code
	output logic [nkc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import nkc_pkg::*;

	logic              valid_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              ready_s1;

	logic              stg_valid  [FIRST_NEIGHBORS];
	logic              stg_ready  [FIRST_NEIGHBORS];
	logic [REST_W-1:0] stg_rest   [FIRST_NEIGHBORS];
	nkc_counts_t       stg_counts [FIRST_NEIGHBORS];
	nkc_result_t       result;

	assign ready_s1      = !valid_s1 || stg_ready[0];
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			key_s1 <= s_axis_tdata[KEY_W-1:0];
		end
	end

	// low digit gives present first neighbors minus one
	always_comb begin
		stg_valid[0]                  = valid_s1;
		stg_rest[0]                   = REST_W'(key_s1 / FIRST_NEIGHBORS);
		stg_counts[0]                 = '0;
		stg_counts[0].present         = FIRST_W'(key_s1 % FIRST_NEIGHBORS) + 1'b1;
	end

	for (genvar f = 0; f < FIRST_NEIGHBORS - 1; f++) begin : g_group
		nkc_group_stage #(
			.STAGE(f)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (stg_valid[f]),
			.in_ready   (stg_ready[f]),
			.in_rest    (stg_rest[f]),
			.in_counts  (stg_counts[f]),
			.out_valid  (stg_valid[f+1]),
			.out_ready  (stg_ready[f+1]),
			.out_rest   (stg_rest[f+1]),
			.out_counts (stg_counts[f+1])
		);
	end

	nkc_result_stage u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (stg_valid[FIRST_NEIGHBORS-1]),
		.in_ready   (stg_ready[FIRST_NEIGHBORS-1]),
		.in_tail    (stg_rest[FIRST_NEIGHBORS-1][TAIL_W-1:0]),
		.in_counts  (stg_counts[FIRST_NEIGHBORS-1]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

>>> rtl/nkc_group_stage.sv
// ----------------------------------------------------------------------------
// nkc_group_stage: slot group extraction stage
// Splits the low base-125 group off the remaining key with a reciprocal
// multiply, decodes its three slots and updates the counts. Registered output.
// ----------------------------------------------------------------------------
module nkc_group_stage #(
	parameter int STAGE = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [nkc_pkg::REST_W-1:0] in_rest,
	input  nkc_pkg::nkc_counts_t      in_counts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [nkc_pkg::REST_W-1:0] out_rest,
	output nkc_pkg::nkc_counts_t      out_counts
);
	import nkc_pkg::*;

	localparam int IN_W   = REST_W - STAGE * GROUP_SHIFT;
	localparam int QW     = IN_W - GROUP_SHIFT;
	localparam int SH     = IN_W + GROUP_BITS;
	localparam int PROD_W = 2 * IN_W + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(GROUP_RADIX) - 64'd1) / 64'(GROUP_RADIX);
	localparam logic [IN_W:0] RECIP = (IN_W + 1)'(RECIP_L);

	logic [IN_W-1:0]       x;
	logic [PROD_W-1:0]     prod;
	logic [QW-1:0]         quot;
	nkc_group_val_t        rem;
	nkc_counts_t           counts_next;
	logic                  valid_q;
	logic [REST_W-1:0]     rest_q;
	nkc_counts_t           counts_q;

	assign x    = in_rest[IN_W-1:0];
	assign prod = PROD_W'(x) * PROD_W'(RECIP);
	assign quot = prod[SH +: QW];
	assign rem  = x[GROUP_BITS-1:0] - GROUP_BITS'(quot[GROUP_BITS-1:0] *
		GROUP_BITS'(GROUP_RADIX));

	assign counts_next = add_group(in_counts, GROUP_TABLE[rem], STAGE);

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rest_q   <= REST_W'(quot);
			counts_q <= counts_next;
		end
	end

	assign out_valid  = valid_q;
	assign out_rest   = rest_q;
	assign out_counts = counts_q;

endmodule

>>> rtl/nkc_result_stage.sv
// ----------------------------------------------------------------------------
// nkc_result_stage: last group and class code
// Decodes the top slot group, finishes the counts, forms the decimal class
// code and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module nkc_result_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [nkc_pkg::TAIL_W-1:0] in_tail,
	input  nkc_pkg::nkc_counts_t      in_counts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output nkc_pkg::nkc_result_t      out_result
);
	import nkc_pkg::*;

	logic [TAIL_W-1:0] tail_mod;
	nkc_counts_t       c;
	logic [CODE_W-1:0] code;
	nkc_result_t       result_next;
	logic              valid_q;
	nkc_result_t       result_q;

	// tail stays below twice the group radix
	assign tail_mod = (in_tail >= TAIL_W'(GROUP_RADIX)) ?
		in_tail - TAIL_W'(GROUP_RADIX) : in_tail;

	assign c = add_group(in_counts, GROUP_TABLE[tail_mod[GROUP_BITS-1:0]],
		FIRST_NEIGHBORS - 1);

	assign code =
		CODE_W'(mod_ten(SECOND_W'(c.surface_first))) * CODE_W'(DEC_THOUSANDS) +
		CODE_W'(mod_ten(SECOND_W'(c.volume_first))) * CODE_W'(DEC_HUNDREDS) +
		CODE_W'(mod_ten(c.volume_second)) * CODE_W'(DEC_TENS) +
		CODE_W'(mod_ten(c.indirect_second));

	always_comb begin
		result_next.first_present   = c.present;
		result_next.surface_first   = c.surface_first;
		result_next.volume_first    = c.volume_first;
		result_next.volume_second   = c.volume_second;
		result_next.surface_second  = c.surface_second;
		result_next.indirect_second = c.indirect_second;
		result_next.class_code      = code;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= result_next;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

>>> tb/sv/tb_neighbor_key_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_neighbor_key_classifier_core: neighbor key classifier testbench
// Streams neighborhood keys into the classifier and checks every result field
// against a local classification, or given values for the typed rows. A short
// table of corner keys comes first (low digit extremes, all-absent and
// all-volume groups, keys above the legal range), then biased random keys.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_neighbor_key_classifier_core;

	import nkc_pkg::*;

	localparam int          SLOTS       = FIRST_NEIGHBORS * SECONDS_PER_FIRST;
	localparam int unsigned KEY_TOP     = (SLOT_RADIX ** SLOTS) * FIRST_NEIGHBORS - 1;
	localparam int          RANDOM_KEYS = 600;
	localparam int          DRAIN_LIMIT = 5000;

	typedef struct {
		logic [KEY_W-1:0] key;
		bit               typed;
		nkc_result_t      want;
	} key_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	nkc_result_t pending_classes[$];
	key_row_t    directed_rows[$];
	int unsigned error_count = 0;
	int unsigned burst_left  = 1;

	neighbor_key_classifier_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("neighbor_key_classifier_core verification failed");
		$finish;
	end

	function automatic nkc_result_t classify_key(logic [KEY_W-1:0] key);
		nkc_result_t r;
		int unsigned rest;
		int unsigned present;
		int unsigned slot;
		int unsigned surf1;
		int unsigned vol1;
		int unsigned vol2;
		int unsigned surf2;
		int unsigned indirect;
		bit          missing;
		present  = key % FIRST_NEIGHBORS + 1;
		rest     = key / FIRST_NEIGHBORS;
		surf1    = 0;
		vol1     = 0;
		vol2     = 0;
		surf2    = 0;
		indirect = 0;
		for (int unsigned f = 0; f < FIRST_NEIGHBORS; f++) begin
			missing = 1'b0;
			for (int s = 0; s < SECONDS_PER_FIRST; s++) begin
				slot = rest % SLOT_RADIX;
				rest = rest / SLOT_RADIX;
				if (slot == SLOT_ABSENT) begin
					missing = 1'b1;
				end else if (f < present) begin
					if (slot == SLOT_VOLUME) begin
						vol2++;
					end else begin
						surf2++;
					end
				end else begin
					indirect++;
				end
			end
			if (f < present) begin
				if (missing) begin
					surf1++;
				end else begin
					vol1++;
				end
			end
		end
		r.first_present   = FIRST_W'(present);
		r.surface_first   = FIRST_W'(surf1);
		r.volume_first    = FIRST_W'(vol1);
		r.volume_second   = SECOND_W'(vol2);
		r.surface_second  = SECOND_W'(surf2);
		r.indirect_second = SECOND_W'(indirect);
		r.class_code      = CODE_W'((surf1 % DEC_RADIX) * DEC_THOUSANDS
			+ (vol1 % DEC_RADIX) * DEC_HUNDREDS + (vol2 % DEC_RADIX) * DEC_TENS
			+ indirect % DEC_RADIX);
		return r;
	endfunction

	// slot i sits in nibble i, first neighbor 0 in the lowest three nibbles
	function automatic logic [KEY_W-1:0] pack_key(logic [PRESENT_W-1:0] low,
			logic [4*SLOTS-1:0] slots);
		int unsigned k;
		k = 0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			k = k * SLOT_RADIX + slots[4*i +: 4];
		end
		k = k * FIRST_NEIGHBORS + low;
		return KEY_W'(k);
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		logic [4*SLOTS-1:0] slots;
		int unsigned        pick;
		int unsigned        mode;
		pick = $urandom_range(0, 9);
		if (pick == 9) begin
			return KEY_W'($urandom());
		end
		if (pick >= 7) begin
			return KEY_W'($urandom_range(0, KEY_TOP));
		end
		for (int f = 0; f < FIRST_NEIGHBORS; f++) begin
			mode = $urandom_range(0, 3);
			for (int s = 0; s < SECONDS_PER_FIRST; s++) begin
				case (mode)
					0: slots[4*(f*SECONDS_PER_FIRST+s) +: 4] = 4'(SLOT_ABSENT);
					1: slots[4*(f*SECONDS_PER_FIRST+s) +: 4] = 4'(SLOT_VOLUME);
					default: slots[4*(f*SECONDS_PER_FIRST+s) +: 4] = 4'($urandom_range(0, 4));
				endcase
			end
		end
		return pack_key(PRESENT_W'($urandom_range(0, FIRST_NEIGHBORS - 1)), slots);
	endfunction

	// natural field order: present, surface/volume first, volume/surface second,
	// indirect, class code
	function automatic nkc_result_t counts(int unsigned pres, int unsigned s1,
			int unsigned v1, int unsigned v2, int unsigned s2, int unsigned ind,
			int unsigned code);
		nkc_result_t r;
		r.first_present   = FIRST_W'(pres);
		r.surface_first   = FIRST_W'(s1);
		r.volume_first    = FIRST_W'(v1);
		r.volume_second   = SECOND_W'(v2);
		r.surface_second  = SECOND_W'(s2);
		r.indirect_second = SECOND_W'(ind);
		r.class_code      = CODE_W'(code);
		return r;
	endfunction

	task automatic add_row(input logic [KEY_W-1:0] key, input bit typed,
			input nkc_result_t want);
		key_row_t row;
		row.key   = key;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	task automatic report_error(input string msg);
		if (error_count < 40) begin
			$display("mismatch: %s", msg);
		end
		error_count++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_error($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	task automatic issue_key(input logic [KEY_W-1:0] key, input bit typed,
			input nkc_result_t want);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'(key);
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		pending_classes.push_back(typed ? want : classify_key(key));
		burst_left--;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// receiver stall pattern
	initial begin
		int unsigned mode;
		int unsigned span;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(4, 40);
			for (int unsigned n = 0; n < span; n++) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					3: m_axis_tready <= (n % 4 == 3);
					default: m_axis_tready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		nkc_result_t got;
		nkc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = nkc_result_t'(m_axis_tdata[RESULT_W-1:0]);
			if (pending_classes.size() == 0) begin
				report_error($sformatf("result %h with no transaction pending", m_axis_tdata));
			end else begin
				want = pending_classes.pop_front();
				compare_field("first_present", got.first_present, want.first_present);
				compare_field("surface_first", got.surface_first, want.surface_first);
				compare_field("volume_first", got.volume_first, want.volume_first);
				compare_field("volume_second", got.volume_second, want.volume_second);
				compare_field("surface_second", got.surface_second, want.surface_second);
				compare_field("indirect_second", got.indirect_second, want.indirect_second);
				compare_field("class_code", got.class_code, want.class_code);
			end
		end
	end

	initial begin
		int unsigned drain;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;

		// all surface slots, one present
		add_row(pack_key(0, 48'h000_000_000_000), 1, counts(1, 0, 1, 0, 3, 9, 109));
		// highest legal key: all absent, four present
		add_row(pack_key(3, 48'h444_444_444_444), 1, counts(4, 4, 0, 0, 0, 0, 4000));
		// volume count wraps in the class code
		add_row(pack_key(3, 48'h333_333_333_333), 1, counts(4, 0, 4, 12, 0, 0, 420));
		add_row(pack_key(0, 48'h333_333_333_333), 1, counts(1, 0, 1, 3, 0, 9, 139));
		add_row(pack_key(0, 48'h444_444_444_444), 1, counts(1, 1, 0, 0, 0, 0, 1000));
		// first key above range: weight past the top slot is dropped
		add_row(30'd976562500, 1, counts(1, 0, 1, 0, 3, 9, 109));
		add_row(30'h3FFF_FFFF, 0, '0);
		add_row(30'h2AAA_AAAA, 0, '0);
		add_row(30'h1555_5555, 0, '0);
		add_row(30'h3A34_0000, 0, '0);
		add_row(pack_key(3, 48'h000_000_000_000), 0, '0);
		add_row(pack_key(1, 48'h444_444_012_321), 0, '0);
		add_row(pack_key(2, 48'h012_443_210_340), 0, '0);
		add_row(pack_key(0, 48'h333_222_111_000), 0, '0);
		add_row(pack_key(1, 48'h404_040_430_043), 0, '0);
		add_row(pack_key(2, 48'h443_434_344_000), 0, '0);
		add_row(pack_key(3, 48'h210_401_333_124), 0, '0);
		add_row(pack_key(0, 48'h344_434_443_333), 0, '0);
		add_row(pack_key(2, 48'h333_444_333_333), 0, '0);
		add_row(pack_key(1, 48'h222_111_434_343), 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);

		foreach (directed_rows[i]) begin
			issue_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want);
		end
		repeat (RANDOM_KEYS) issue_key(random_key(), 0, '0);
		s_axis_tvalid <= 1'b0;

		drain = 0;
		while (pending_classes.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);
		if (pending_classes.size() != 0) begin
			report_error($sformatf("%0d results never arrived", pending_classes.size()));
		end

		if (error_count == 0) begin
			$display("neighbor_key_classifier_core verification clean");
		end else begin
			$display("neighbor_key_classifier_core verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/nkc_pkg.sv
rtl/nkc_group_stage.sv
rtl/nkc_result_stage.sv
rtl/neighbor_key_classifier_core.sv
tb/sv/tb_neighbor_key_classifier_core.sv
